// ===== hdl/mme_pkg.sv =====
// Shared constants for the Montgomery modular exponentiation block.
// Used by mme_mont and montgomery_modular_exponentiation; no dependencies.
package mme_pkg;

	// operand width of the arithmetic datapath
	localparam int KEY_BITS = 32;
	// width of the stream and configuration fields
	localparam int DATA_W   = 32;
	// counter wide enough to hold KEY_BITS itself
	localparam int CNT_W    = $clog2(KEY_BITS + 1);

	// configuration register indexes
	localparam logic REG_MODULUS  = 1'b0;
	localparam logic REG_EXPONENT = 1'b1;

	// reset values of the configuration registers
	localparam logic [KEY_BITS-1:0] MODULUS_RST  = KEY_BITS'(3233);
	localparam logic [KEY_BITS-1:0] EXPONENT_RST = KEY_BITS'(17);

endpackage

// ===== hdl/mme_mont.sv =====
// Radix-2 bit-serial Montgomery product: res = x * y * 2^-n mod m.
// One multiplier bit per cycle, then one conditional subtraction. Uses mme_pkg.
module mme_mont
	import mme_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [KEY_BITS-1:0] op_x,
	input  logic [KEY_BITS-1:0] op_y,
	input  logic [KEY_BITS-1:0] mod,
	input  logic [CNT_W-1:0]    nbits,
	output logic                done,
	output logic [KEY_BITS-1:0] res
);

	localparam int W = KEY_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_STEP = 2'd1;
	localparam logic [1:0] ST_FIX  = 2'd2;

	logic [1:0]       state_q;
	logic [W-1:0]     x_q;
	logic [W-1:0]     y_q;
	logic [W-1:0]     m_q;
	logic [W:0]       ym_q;
	logic [W:0]       t_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [W-1:0]     res_q;

	logic             xi;
	logic             qbit;
	logic [W:0]       addend;
	logic [W+1:0]     sum;
	logic [W+1:0]     diff;

	// pick the addend from the multiplier bit and the parity bit
	always_comb begin
		xi   = x_q[0];
		qbit = t_q[0] ^ (xi & y_q[0]);
		case ({qbit, xi})
			2'b00:   addend = '0;
			2'b01:   addend = {1'b0, y_q};
			2'b10:   addend = {1'b0, m_q};
			default: addend = ym_q;
		endcase
		sum  = {1'b0, t_q} + {1'b0, addend};
		diff = {1'b0, t_q} - {2'b00, m_q};
	end

	// step the product one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			x_q   <= op_x;
			y_q   <= op_y;
			m_q   <= mod;
			ym_q  <= {1'b0, op_y} + {1'b0, mod};
			t_q   <= '0;
			cnt_q <= nbits;
		end else if (state_q == ST_STEP) begin
			x_q   <= {1'b0, x_q[W-1:1]};
			t_q   <= sum[W+1:1];
			cnt_q <= cnt_q - CNT_W'(1);
		end else if (state_q == ST_FIX) begin
			// one conditional subtraction brings t below m
			res_q <= diff[W+1] ? t_q[W-1:0] : diff[W-1:0];
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== hdl/montgomery_modular_exponentiation.sv =====
// Modular exponentiation: result = message ^ exponent mod modulus.
// Input stream s_* carries one message per transaction; output stream m_*
// carries one result per message, with the error flag in m_tuser.
// Configuration channel cfg_* writes the modulus (index 0) or the exponent
// (index 1); cfg_ready is always high. Write it only while the block is idle.
// Per message: find n, the bit length of the modulus, by shifting it up,
// then R^2 mod M by 2n shift-subtract steps, then 2 + w + b + 1 Montgomery
// products, where w is the bit length of the exponent and b its count of
// one bits, all on the shared bit-serial product unit.
// An even modulus or a message not below the modulus gives result 0 and
// error 1 without any products. One message is worked at a time; s_tready
// rises again when the result moves into the output register, which may
// hold it while m_tready is low. Reset loads modulus 3233 and exponent 17
// and empties the output register.
// Uses mme_pkg and mme_mont.
module montgomery_modular_exponentiation
	import mme_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// input stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // [31:0] message
	// output stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // [31:0] result
	output logic [0:0]        m_tuser,   // [0] error
	// configuration writes
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [DATA_W-1:0] cfg_data
);

	localparam int W = KEY_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_NLEN = 3'd1;
	localparam logic [2:0] ST_RSQ  = 3'd2;
	localparam logic [2:0] ST_GO   = 3'd3;
	localparam logic [2:0] ST_WAIT = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	// which Montgomery product is in flight
	localparam logic [2:0] PR_Z0  = 3'd0;
	localparam logic [2:0] PR_P0  = 3'd1;
	localparam logic [2:0] PR_MUL = 3'd2;
	localparam logic [2:0] PR_SQ  = 3'd3;
	localparam logic [2:0] PR_FIN = 3'd4;

	logic [2:0]       state_q;
	logic [2:0]       prod_q;
	logic [W-1:0]     modulus_q;
	logic [W-1:0]     exponent_q;
	logic [W-1:0]     msg_q;
	logic [W-1:0]     m_q;
	logic [W-1:0]     e_q;
	logic [W-1:0]     scan_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W:0]   rcnt_q;
	logic [W-1:0]     rr_q;
	logic [W-1:0]     z_q;
	logic [W-1:0]     p_q;
	logic [W-1:0]     res_q;
	logic             err_q;
	logic             out_valid_q;
	logic [W-1:0]     out_data_q;
	logic             out_err_q;

	logic             in_fire;
	logic [W-1:0]     in_msg;
	logic             in_bad;
	logic [W:0]       rr_dbl;
	logic [W+1:0]     rr_diff;
	logic [W-1:0]     e_shr;
	logic             mm_start;
	logic [W-1:0]     mm_x;
	logic [W-1:0]     mm_y;
	logic             mm_done;
	logic [W-1:0]     mm_res;
	logic             out_load;

	assign in_fire   = s_tvalid && s_tready;
	assign in_msg    = W'(s_tdata);
	assign in_bad    = !modulus_q[0] || (in_msg >= modulus_q);
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || m_tready);

	// doubling step of R^2 mod M
	assign rr_dbl  = {rr_q, 1'b0};
	assign rr_diff = {1'b0, rr_dbl} - {2'b00, m_q};
	assign e_shr   = {1'b0, e_q[W-1:1]};

	// operand select for the product unit
	always_comb begin
		case (prod_q)
			PR_Z0:   begin mm_x = W'(1); mm_y = rr_q; end
			PR_P0:   begin mm_x = msg_q; mm_y = rr_q; end
			PR_MUL:  begin mm_x = z_q;   mm_y = p_q;  end
			PR_SQ:   begin mm_x = p_q;   mm_y = p_q;  end
			default: begin mm_x = W'(1); mm_y = z_q;  end
		endcase
	end

	assign mm_start = (state_q == ST_GO);

	mme_mont u_mont (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.op_x   (mm_x),
		.op_y   (mm_y),
		.mod    (m_q),
		.nbits  (n_q),
		.done   (mm_done),
		.res    (mm_res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= MODULUS_RST;
			exponent_q <= EXPONENT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODULUS:  modulus_q  <= W'(cfg_data);
				REG_EXPONENT: exponent_q <= W'(cfg_data);
				default:      ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prod_q  <= PR_Z0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= in_bad ? ST_OUT : ST_NLEN;
					end
				end
				ST_NLEN: begin
					if (scan_q[W-1]) begin
						state_q <= ST_RSQ;
					end
				end
				ST_RSQ: begin
					if (rcnt_q == (CNT_W+1)'(1)) begin
						state_q <= ST_GO;
						prod_q  <= PR_Z0;
					end
				end
				ST_GO: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (mm_done) begin
						state_q <= ST_GO;
						case (prod_q)
							PR_Z0:  prod_q <= PR_P0;
							PR_MUL: prod_q <= PR_SQ;
							PR_P0: begin
								if (e_q == '0) begin
									prod_q <= PR_FIN;
								end else if (e_q[0]) begin
									prod_q <= PR_MUL;
								end else begin
									prod_q <= PR_SQ;
								end
							end
							PR_SQ: begin
								if (e_shr == '0) begin
									prod_q <= PR_FIN;
								end else if (e_shr[0]) begin
									prod_q <= PR_MUL;
								end else begin
									prod_q <= PR_SQ;
								end
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					msg_q  <= in_msg;
					m_q    <= modulus_q;
					e_q    <= exponent_q;
					scan_q <= modulus_q;
					n_q    <= CNT_W'(KEY_BITS);
					rr_q   <= (modulus_q == W'(1)) ? '0 : W'(1);
					res_q  <= '0;
					err_q  <= in_bad;
				end
			end
			ST_NLEN: begin
				// shift until the top bit of the modulus shows
				if (scan_q[W-1]) begin
					rcnt_q <= {n_q, 1'b0};
				end else begin
					scan_q <= {scan_q[W-2:0], 1'b0};
					n_q    <= n_q - CNT_W'(1);
				end
			end
			ST_RSQ: begin
				rr_q   <= rr_diff[W+1] ? rr_dbl[W-1:0] : rr_diff[W-1:0];
				rcnt_q <= rcnt_q - (CNT_W+1)'(1);
			end
			ST_WAIT: begin
				if (mm_done) begin
					case (prod_q)
						PR_Z0:  z_q <= mm_res;
						PR_P0:  p_q <= mm_res;
						PR_MUL: z_q <= mm_res;
						PR_SQ: begin
							p_q <= mm_res;
							e_q <= e_shr;
						end
						default: res_q <= mm_res;
					endcase
				end
			end
			default: ;
		endcase
	end

	// output register: load on completion, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= res_q;
			out_err_q  <= err_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = DATA_W'(out_data_q);
	assign m_tuser  = out_err_q;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for montgomery_modular_exponentiation.
// Drives messages and register writes, predicts message^exponent mod modulus
// in a scoreboard class. Depends on mme_pkg and the block's RTL only.
`timescale 1ns / 100ps

module testbench;
	import mme_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;

	// one expected output transaction
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              error;
	} power_result_t;

	// Tracks the register copies and the queue of pending powers.
	class power_scoreboard;
		logic [KEY_BITS-1:0] modulus = MODULUS_RST;
		logic [KEY_BITS-1:0] exponent = EXPONENT_RST;
		power_result_t pending_powers[$];
		int messages = 0;
		int flagged = 0;
		int checked = 0;
		int mismatches = 0;

		function int unsigned width_of(logic [63:0] v);
			int unsigned n;
			n = 0;
			while (v != 0) begin
				v = v >> 1;
				n++;
			end
			return n;
		endfunction

		// bit-serial Montgomery product a*b*2^-n mod m
		function logic [63:0] mont_product(logic [63:0] a, logic [63:0] b,
			logic [63:0] m, int unsigned n);
			logic [63:0] t;
			logic q;
			t = 0;
			for (int i = 0; i < n; i++) begin
				q = t[0] ^ (a[i] & b[0]);
				t = (t + (a[i] ? b : 64'd0) + (q ? m : 64'd0)) >> 1;
			end
			if (t >= m)
				t = t - m;
			return t;
		endfunction

		// Work out the power for one accepted message and queue it.
		function void note_message(logic [DATA_W-1:0] msg);
			power_result_t want;
			logic [63:0] m, x, e, rr, z, p;
			int unsigned n, ebits;
			m = modulus;
			x = msg;
			e = exponent;
			messages++;
			if (!m[0] || x >= m) begin
				want.value = '0;
				want.error = 1'b1;
				flagged++;
			end else begin
				n = width_of(m);
				// R^2 mod M by doubling
				rr = 64'd1 % m;
				for (int i = 0; i < 2 * n; i++) begin
					rr = rr << 1;
					if (rr >= m)
						rr = rr - m;
				end
				z = mont_product(64'd1, rr, m, n);
				p = mont_product(x, rr, m, n);
				// right-to-left square and multiply
				ebits = width_of(e);
				for (int i = 0; i < ebits; i++) begin
					if (e[i])
						z = mont_product(z, p, m, n);
					p = mont_product(p, p, m, n);
				end
				want.value = DATA_W'(mont_product(64'd1, z, m, n));
				want.error = 1'b0;
			end
			pending_powers.push_back(want);
		endfunction

		// Compare one output transaction with the oldest pending power.
		function void check_result(logic [DATA_W-1:0] value, logic error);
			power_result_t want;
			if (pending_powers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %h error %0b arrived with nothing pending",
						value, error);
				return;
			end
			want = pending_powers.pop_front();
			checked++;
			if (value !== want.value || error !== want.error) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result #%0d: expected %h error %0b, got %h error %0b",
						checked, want.value, want.error, value, error);
			end
		endfunction

		function int pending();
			return pending_powers.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic [0:0]        m_tuser;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic              cfg_index = REG_MODULUS;
	logic [DATA_W-1:0] cfg_data = '0;

	power_scoreboard powers = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int settings = 0;
	int cycle_count = 0;

	montgomery_modular_exponentiation dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the output at random and check each result transaction.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && m_tvalid && m_tready)
			powers.check_result(m_tdata, m_tuser[0]);
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Write modulus then exponent back to back; hold valid across both.
	task automatic configure(logic [DATA_W-1:0] modulus, logic [DATA_W-1:0] exponent);
		cfg_valid <= 1'b1;
		cfg_index <= REG_MODULUS;
		cfg_data <= modulus;
		do @(posedge clk); while (!cfg_ready);
		powers.modulus = modulus;
		cfg_index <= REG_EXPONENT;
		cfg_data <= exponent;
		do @(posedge clk); while (!cfg_ready);
		powers.exponent = exponent;
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// Offer one message after a random idle stretch; note it once taken.
	task automatic send_message(logic [DATA_W-1:0] msg);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= msg;
		do @(posedge clk); while (!s_tready);
		powers.note_message(msg);
	endtask

	// Drop valid and hold off until every pending power has come out.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (powers.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Odd modulus of the given width, top bit set; one in ten made even.
	function automatic logic [DATA_W-1:0] pick_modulus(int unsigned bits);
		logic [DATA_W-1:0] v;
		v = $urandom;
		if (bits < DATA_W)
			v = v & ((DATA_W'(1) << bits) - 1);
		v[bits-1] = 1'b1;
		v[0] = ($urandom_range(9) != 0);
		return v;
	endfunction

	function automatic logic [DATA_W-1:0] pick_exponent(int unsigned bits);
		logic [DATA_W-1:0] v;
		if (bits == 0)
			return '0;
		v = $urandom;
		if (bits < DATA_W)
			v = v & ((DATA_W'(1) << bits) - 1);
		v[bits-1] = 1'b1;
		return v;
	endfunction

	// Mostly valid bases, some at the top of the range, some out of range.
	function automatic logic [DATA_W-1:0] pick_message(logic [DATA_W-1:0] modulus);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 80)
			return (modulus == 0) ? $urandom : $urandom_range(modulus - 1, 0);
		else if (r < 86)
			return modulus - 1;
		else if (r < 95)
			return $urandom;
		else
			return modulus;
	endfunction

	initial begin
		logic [DATA_W-1:0] modulus;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		drain();

		// directed: reset setting, range edges and out-of-range bases
		send_message(0);
		send_message(1);
		send_message(3232);
		send_message(3233);
		send_message('1);
		drain();
		// modulus of one
		configure(1, 5);
		send_message(0);
		send_message(1);
		drain();
		// even moduli, zero among them
		configure(3234, 17);
		send_message(5);
		drain();
		configure(0, 3);
		send_message(0);
		send_message(32'h8000_0000);
		drain();
		// widest modulus with zero and full exponent
		configure('1, 0);
		send_message(0);
		send_message(32'hFFFF_FFFE);
		drain();
		configure('1, '1);
		send_message(32'hFFFF_FFFE);
		send_message(2);
		drain();
		configure(3, '1);
		send_message(2);
		send_message(1);
		drain();
		configure(32'h8000_0001, 32'h0001_0001);
		send_message(32'h1234_5678);
		drain();

		// random: four idling phases, mostly narrow settings, one full-width per phase
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			for (int k = 0; k < 6; k++) begin
				if (k == 5) begin
					modulus = pick_modulus(32);
					configure(modulus, pick_exponent(32));
				end else begin
					modulus = pick_modulus($urandom_range(16, 2));
					configure(modulus, pick_exponent($urandom_range(12, 0)));
				end
				for (int i = 0; i < ((k == 5) ? 3 : 11); i++)
					send_message(pick_message(modulus));
				drain();
			end
		end

		repeat (20) @(posedge clk);
		$display("Covered %0d messages (%0d flagged in error) across %0d register settings.",
			powers.messages, powers.flagged, settings);
		$display("%0d results checked, %0d mismatches.", powers.checked, powers.mismatches);
		if (powers.mismatches == 0 && powers.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
